// File: rtl/core/pps_pkg.sv
// Package for the prime pair sum finder: sequencer step codes, datapath operations,
// jump conditions and the control store of the sequencer.
// Depends on nothing; imported by prime_pair_sum_finder_top.
package pps_pkg;

  localparam int TARGET_W = 16;
  localparam int RESULT_W = 17;

  localparam logic signed [RESULT_W-1:0] NO_PAIR     = -17'sd1;
  localparam logic [TARGET_W-1:0]        FIRST_PRIME = 16'd2;
  localparam logic [TARGET_W:0]          FIRST_SQ    = 17'd4;

  typedef logic [3:0] step_t;

  localparam step_t S_IDLE   = 4'd0;
  localparam step_t S_CHK    = 4'd1;
  localparam step_t S_INIT   = 4'd2;
  localparam step_t S_PSTART = 4'd3;
  localparam step_t S_PTEST  = 4'd4;
  localparam step_t S_PREAD  = 4'd5;
  localparam step_t S_MARK   = 4'd6;
  localparam step_t S_PNEXT  = 4'd7;
  localparam step_t S_SSTART = 4'd8;
  localparam step_t S_STEST  = 4'd9;
  localparam step_t S_SRD1   = 4'd10;
  localparam step_t S_SRD2   = 4'd11;
  localparam step_t S_SNEXT  = 4'd12;
  localparam step_t S_FOUND  = 4'd13;
  localparam step_t S_NOPAIR = 4'd14;

  localparam int NUM_STEPS = 15;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_INIT,
    OP_P_START,
    OP_READ_P,
    OP_M_START,
    OP_MARK,
    OP_P_NEXT,
    OP_READ_Q,
    OP_FOUND,
    OP_NOPAIR
  } op_t;

  typedef enum logic [3:0] {
    C_ALWAYS,
    C_IN_VALID,
    C_OVERSIZE,
    C_I_LAST,
    C_SQ_GT_N,
    C_RD_ZERO,
    C_M_GT_N,
    C_P2_GT_N,
    C_OUT_FREE
  } cond_t;

  // When the condition holds the sequencer takes jump, otherwise next.
  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t jump;
    step_t next;
  } uword_t;

  localparam uword_t UCODE [NUM_STEPS] = '{
    '{OP_ACCEPT,  C_IN_VALID, S_CHK,    S_IDLE},    // S_IDLE
    '{OP_NONE,    C_OVERSIZE, S_NOPAIR, S_INIT},    // S_CHK
    '{OP_INIT,    C_I_LAST,   S_PSTART, S_INIT},    // S_INIT
    '{OP_P_START, C_ALWAYS,   S_PTEST,  S_PTEST},   // S_PSTART
    '{OP_READ_P,  C_SQ_GT_N,  S_SSTART, S_PREAD},   // S_PTEST
    '{OP_M_START, C_RD_ZERO,  S_PNEXT,  S_MARK},    // S_PREAD
    '{OP_MARK,    C_M_GT_N,   S_PNEXT,  S_MARK},    // S_MARK
    '{OP_P_NEXT,  C_ALWAYS,   S_PTEST,  S_PTEST},   // S_PNEXT
    '{OP_P_START, C_ALWAYS,   S_STEST,  S_STEST},   // S_SSTART
    '{OP_READ_P,  C_P2_GT_N,  S_NOPAIR, S_SRD1},    // S_STEST
    '{OP_READ_Q,  C_RD_ZERO,  S_SNEXT,  S_SRD2},    // S_SRD1
    '{OP_NONE,    C_RD_ZERO,  S_SNEXT,  S_FOUND},   // S_SRD2
    '{OP_P_NEXT,  C_ALWAYS,   S_STEST,  S_STEST},   // S_SNEXT
    '{OP_FOUND,   C_OUT_FREE, S_IDLE,   S_FOUND},   // S_FOUND
    '{OP_NOPAIR,  C_OUT_FREE, S_IDLE,   S_NOPAIR}   // S_NOPAIR
  };

endpackage

// File: rtl/core/prime_pair_sum_finder_top.sv
// Prime pair sum finder: microcoded sequencer, sieve bitmap memory and result register.
// Depends on pps_pkg for the control store, step codes and constants.
//
//   channel  valid         stall         payload
//   item     item_valid    item_stall    target
//   result   result_valid  result_stall  smaller_prime, larger_prime
//
// A target n first fills the bitmap for 0..n, then sieves each candidate p with p*p <= n
// (striking its multiples from p*p when p is still marked prime), then searches p upward
// while 2p <= n for p and n - p both prime. The single port of the bitmap is shared by
// all of these steps, and every step touches it at most once.
// Reset returns the sequencer to idle and empties the result register; the bitmap is not
// cleared. A new transaction is taken while the previous result waits, and the sequencer
// holds at its last step while the result register is full and its result is stalled.
module prime_pair_sum_finder_top
  import pps_pkg::*;
#(
  parameter int MAX_TARGET = 65535
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  logic [TARGET_W-1:0]        target,
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic signed [RESULT_W-1:0] smaller_prime,
  output logic signed [RESULT_W-1:0] larger_prime
);

  localparam int DEPTH = MAX_TARGET + 1;
  localparam int AW    = $clog2(DEPTH);

  step_t  pc;
  step_t  pc_next;
  uword_t uw;
  logic   cond_true;

  logic [TARGET_W-1:0] n;
  logic [TARGET_W-1:0] i;
  logic [TARGET_W-1:0] p;
  logic [TARGET_W-1:0] q;
  logic [TARGET_W:0]   sq;
  logic [TARGET_W:0]   m;
  logic [TARGET_W:0]   n_ext;

  logic          map [DEPTH];
  logic          rd;
  logic          mem_we;
  logic          mem_wdata;
  logic [TARGET_W:0] addr_val;
  logic [AW-1:0] mem_addr;

  logic out_free;
  logic out_load;
  logic m_gt_n;

  assign uw       = UCODE[pc];
  assign n_ext    = {1'b0, n};
  assign q        = n - p;
  assign m_gt_n   = m > n_ext;
  assign out_free = !result_valid || !result_stall;
  assign item_stall = (uw.op != OP_ACCEPT);
  assign out_load = ((uw.op == OP_FOUND) || (uw.op == OP_NOPAIR)) && out_free;

  always_comb begin
    unique case (uw.cond)
      C_ALWAYS:   cond_true = 1'b1;
      C_IN_VALID: cond_true = item_valid;
      C_OVERSIZE: cond_true = 32'(n) > MAX_TARGET;
      C_I_LAST:   cond_true = (i == n);
      C_SQ_GT_N:  cond_true = sq > n_ext;
      C_RD_ZERO:  cond_true = !rd;
      C_M_GT_N:   cond_true = m_gt_n;
      C_P2_GT_N:  cond_true = {p, 1'b0} > n_ext;
      C_OUT_FREE: cond_true = out_free;
      default:    cond_true = 1'b1;
    endcase
    pc_next = cond_true ? uw.jump : uw.next;
  end

  // Bitmap port: address and write enable come straight from the current operation.
  always_comb begin
    unique case (uw.op)
      OP_INIT:   addr_val = {1'b0, i};
      OP_MARK:   addr_val = m;
      OP_READ_Q: addr_val = {1'b0, q};
      default:   addr_val = {1'b0, p};
    endcase
    mem_we    = (uw.op == OP_INIT) || ((uw.op == OP_MARK) && !m_gt_n);
    mem_wdata = (uw.op == OP_INIT) && (i >= FIRST_PRIME);
    mem_addr  = AW'(addr_val);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      map[mem_addr] <= mem_wdata;
    end
    rd <= map[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc           <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      pc <= pc_next;
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (uw.op)
      OP_ACCEPT: begin
        if (item_valid) begin
          n <= target;
          i <= '0;
        end
      end
      OP_INIT: i <= i + 1'b1;
      OP_P_START: begin
        p  <= FIRST_PRIME;
        sq <= FIRST_SQ;
      end
      OP_M_START: m <= sq;
      OP_MARK:    m <= m + {1'b0, p};
      OP_P_NEXT: begin
        // (p + 1)^2 = p^2 + 2p + 1 keeps the bound test free of a multiplier.
        p  <= p + 1'b1;
        sq <= sq + {p, 1'b0} + 1'b1;
      end
      OP_FOUND: begin
        if (out_free) begin
          smaller_prime <= $signed({1'b0, p});
          larger_prime  <= $signed({1'b0, q});
        end
      end
      OP_NOPAIR: begin
        if (out_free) begin
          smaller_prime <= NO_PAIR;
          larger_prime  <= NO_PAIR;
        end
      end
      default: ;
    endcase
  end

endmodule
